// ----- hdl/pbsp_pkg.sv -----
// Package for the plane/box slice polygon core: widths, register indexes,
// edge and face tables. No dependencies.
`default_nettype none
package pbsp_pkg;
   localparam int CoordWidth = 32;
   localparam int DistWidth  = 64;
   localparam int FracWidth  = 31;
   localparam int CsrIdxWidth = 3;
   localparam int DefFifoDepth = 2;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_MIN_X = 3'd0, REG_MAX_X = 3'd1, REG_MIN_Y = 3'd2,
      REG_MAX_Y = 3'd3, REG_MIN_Z = 3'd4, REG_MAX_Z = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] z;
   } vtx_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] a;
      logic signed [CoordWidth-1:0] b;
      logic signed [CoordWidth-1:0] c;
      logic signed [CoordWidth-1:0] d;
   } plane_type;

   typedef struct packed {
      vtx_type [7:0] corner;
   } box_type;

   function automatic logic [2:0] edge_end0(input logic [3:0] e);
      case (e)
         4'd0: return 3'd0;  4'd1: return 3'd1;  4'd2: return 3'd2;
         4'd3: return 3'd3;  4'd4: return 3'd0;  4'd5: return 3'd1;
         4'd6: return 3'd2;  4'd7: return 3'd3;  4'd8: return 3'd4;
         4'd9: return 3'd5;  4'd10: return 3'd6; default: return 3'd7;
      endcase
   endfunction

   function automatic logic [2:0] edge_end1(input logic [3:0] e);
      case (e)
         4'd0: return 3'd1;  4'd1: return 3'd2;  4'd2: return 3'd3;
         4'd3: return 3'd0;  4'd4: return 3'd4;  4'd5: return 3'd5;
         4'd6: return 3'd6;  4'd7: return 3'd7;  4'd8: return 3'd5;
         4'd9: return 3'd6;  4'd10: return 3'd7; default: return 3'd4;
      endcase
   endfunction

   function automatic logic [3:0] face_edge(input logic [2:0] f, input logic [1:0] k);
      logic [15:0] row;
      case (f)
         3'd0: row = {4'd3, 4'd2, 4'd1, 4'd0};
         3'd1: row = {4'd5, 4'd9, 4'd6, 4'd1};
         3'd2: row = {4'd10, 4'd7, 4'd2, 4'd6};
         3'd3: row = {4'd11, 4'd4, 4'd3, 4'd7};
         3'd4: row = {4'd4, 4'd8, 4'd5, 4'd0};
         default: row = {4'd11, 4'd10, 4'd8, 4'd9};
      endcase
      return row[k*4 +: 4];
   endfunction
endpackage
`default_nettype wire

// ----- hdl/pbsp_front.sv -----
// Front end: corner distances and cut flags for one plane.
// Depends on pbsp_pkg.
`default_nettype none
module pbsp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire pbsp_pkg::plane_type  plane,
   input  wire pbsp_pkg::box_type    box,
   output logic                      q_valid,
   input  wire logic                 q_stall,
   output logic signed [63:0]        q_dist [8],
   output logic [11:0]               q_cut
);
   import pbsp_pkg::*;

   typedef enum logic [1:0] {F_IDLE, F_CALC, F_DONE} fstate_type;
   fstate_type state_ff;
   plane_type plane_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] dist_ff [8];
   logic [11:0] cut_w;
   logic [2:0] ci;
   logic [1:0] ai;
   logic signed [31:0] mc, mk;
   vtx_type cv;

   // Step order: for each corner, three products (step counts 0..2 per axis).
   logic [2:0] corner_ff;
   logic [1:0] axis_ff;
   logic       prod_vld_ff;
   logic [2:0] pc_ff;

   assign ci = corner_ff;
   assign ai = axis_ff;
   always_comb begin
      cv = box.corner[ci];
      case (ai)
         2'd0: begin mc = cv.x; mk = plane_ff.a; end
         2'd1: begin mc = cv.y; mk = plane_ff.b; end
         default: begin mc = cv.z; mk = plane_ff.c; end
      endcase
   end

   always_comb begin
      for (int e = 0; e < 12; e++)
         cut_w[e] = (dist_ff[edge_end0(4'(e))] > 0) != (dist_ff[edge_end1(4'(e))] > 0);
   end

   assign req_stall = (state_ff != F_IDLE);
   assign q_valid = (state_ff == F_DONE);
   assign q_dist = dist_ff;
   assign q_cut = cut_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= 1'b0;
         unique case (state_ff)
            F_IDLE: if (req_valid) begin
               plane_ff <= plane;
               corner_ff <= '0;
               axis_ff <= '0;
               for (int i = 0; i < 8; i++) dist_ff[i] <= 64'(signed'(plane.d));
               state_ff <= F_CALC;
            end
            F_CALC: begin
               if (!(corner_ff == 3'd7 && axis_ff == 2'd3)) begin
                  prod_ff <= 64'(mc) * 64'(mk);
                  prod_vld_ff <= 1'b1;
                  pc_ff <= corner_ff;
                  if (axis_ff == 2'd2) begin
                     axis_ff <= 2'd0;
                     if (corner_ff == 3'd7) axis_ff <= 2'd3;
                     else corner_ff <= corner_ff + 3'd1;
                  end else axis_ff <= axis_ff + 2'd1;
               end else if (!prod_vld_ff) state_ff <= F_DONE;
               if (prod_vld_ff) dist_ff[pc_ff] <= dist_ff[pc_ff] + (prod_ff >>> 16);
            end
            F_DONE: if (!q_stall) state_ff <= F_IDLE;
            default: state_ff <= F_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- hdl/pbsp_queue.sv -----
// Short queue of classified items between front and back ends.
// Depends on pbsp_pkg.
`default_nettype none
module pbsp_queue #(
   parameter int Depth = pbsp_pkg::DefFifoDepth
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_stall,
   input  wire logic signed [63:0] in_dist [8],
   input  wire logic [11:0]   in_cut,
   output logic               out_valid,
   input  wire logic          out_stall,
   output logic signed [63:0] out_dist [8],
   output logic [11:0]        out_cut
);
   import pbsp_pkg::*;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   logic signed [63:0] md_ff [Depth][8];
   logic [11:0] mc_ff [Depth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0] cnt_ff;
   logic push, pop;
   assign in_stall = (cnt_ff == (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;
   assign out_dist = md_ff[rp_ff];
   assign out_cut = mc_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) begin
            md_ff[wp_ff] <= in_dist;
            mc_ff[wp_ff] <= in_cut;
            wp_ff <= (wp_ff == AW'(Depth-1)) ? '0 : wp_ff + 1'b1;
         end
         if (pop) rp_ff <= (rp_ff == AW'(Depth-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule
`default_nettype wire

// ----- hdl/pbsp_back.sv -----
// Back end: cut points by serial division, face segments, chaining, emit.
// Depends on pbsp_pkg.
`default_nettype none
module pbsp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_stall,
   input  wire logic signed [63:0] in_dist [8],
   input  wire logic [11:0]        in_cut,
   input  wire pbsp_pkg::box_type  box,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output pbsp_pkg::vtx_type       rsp_vtx,
   output logic [2:0]              rsp_index,
   output logic                    rsp_last
);
   import pbsp_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE, B_EDGE, B_DIV, B_LERP, B_LADD, B_FACE, B_CHAIN, B_EMIT
   } bstate_type;
   bstate_type state_ff;

   logic signed [63:0] dist_ff [8];
   logic [11:0] cut_ff;
   vtx_type cutp_ff [12];
   vtx_type seg_ff [6][2];
   logic [2:0] nseg_ff;
   logic [3:0] edge_ff;
   logic [5:0] dcnt_ff;
   logic [65:0] rem_ff, den_ff;
   logic [30:0] q_ff;
   logic [1:0] axis_ff;
   logic [63:0] lprod_ff;
   logic ldneg_ff;
   logic signed [31:0] lp1_ff;
   logic [2:0] face_ff, ci_ff, cj_ff;
   logic [2:0] oi_ff;
   vtx_type p0, p1;
   logic signed [31:0] c0, c1;
   logic signed [32:0] diff;
   logic [32:0] dmag;
   logic [65:0] rsh;
   logic [63:0] m0, m1;
   logic [63:0] off;

   assign in_stall = (state_ff != B_IDLE);
   assign p0 = box.corner[edge_end0(edge_ff)];
   assign p1 = box.corner[edge_end1(edge_ff)];
   always_comb begin
      case (axis_ff)
         2'd0: begin c0 = p0.x; c1 = p1.x; end
         2'd1: begin c0 = p0.y; c1 = p1.y; end
         default: begin c0 = p0.z; c1 = p1.z; end
      endcase
      diff = 33'(c0) - 33'(c1);
      dmag = diff[32] ? 33'(-diff) : diff;
      rsh = {rem_ff[64:0], 1'b0};
      m0 = dist_ff[edge_end0(edge_ff)][63] ? 64'(-dist_ff[edge_end0(edge_ff)])
                                            : dist_ff[edge_end0(edge_ff)];
      m1 = dist_ff[edge_end1(edge_ff)][63] ? 64'(-dist_ff[edge_end1(edge_ff)])
                                            : dist_ff[edge_end1(edge_ff)];
      off = (lprod_ff + 64'd536870912) >> 30;
   end

   assign rsp_valid = (state_ff == B_EMIT);
   assign rsp_vtx = seg_ff[oi_ff][0];
   assign rsp_index = oi_ff;
   assign rsp_last = (oi_ff == nseg_ff - 3'd1);

   always_ff @(posedge clock) begin
      logic [1:0] got;
      vtx_type want, t0, t1, s0, s1;
      logic hit0, hit1;
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         unique case (state_ff)
            B_IDLE: if (in_valid) begin
               dist_ff <= in_dist;
               cut_ff <= in_cut;
               edge_ff <= '0;
               state_ff <= B_EDGE;
            end
            B_EDGE: begin
               // skip edges without a sign change
               if (cut_ff[edge_ff]) begin
                  rem_ff <= {2'b0, m1};
                  den_ff <= 66'(m1) + 66'(m0);
                  q_ff <= '0;
                  dcnt_ff <= '0;
                  state_ff <= B_DIV;
               end else if (edge_ff == 4'd11) begin
                  face_ff <= '0; nseg_ff <= '0; state_ff <= B_FACE;
               end else edge_ff <= edge_ff + 4'd1;
            end
            B_DIV: begin
               // one quotient bit a cycle, first bit without shift
               if (dcnt_ff == 6'd0) begin
                  if (rem_ff >= den_ff) begin rem_ff <= rem_ff - den_ff; q_ff <= 31'd1; end
               end else if (rsh >= den_ff) begin
                  rem_ff <= rsh - den_ff; q_ff <= {q_ff[29:0], 1'b1};
               end else begin
                  rem_ff <= rsh; q_ff <= {q_ff[29:0], 1'b0};
               end
               if (dcnt_ff == 6'd30) begin axis_ff <= '0; state_ff <= B_LERP; end
               else dcnt_ff <= dcnt_ff + 6'd1;
            end
            B_LERP: begin
               lprod_ff <= 64'(dmag) * 64'(q_ff);
               ldneg_ff <= diff[32];
               lp1_ff <= c1;
               state_ff <= B_LADD;
            end
            B_LADD: begin
               case (axis_ff)
                  2'd0: cutp_ff[edge_ff].x <= ldneg_ff ? lp1_ff - off[31:0] : lp1_ff + off[31:0];
                  2'd1: cutp_ff[edge_ff].y <= ldneg_ff ? lp1_ff - off[31:0] : lp1_ff + off[31:0];
                  default: cutp_ff[edge_ff].z <= ldneg_ff ? lp1_ff - off[31:0]
                                                          : lp1_ff + off[31:0];
               endcase
               if (axis_ff == 2'd2) begin
                  if (edge_ff == 4'd11) begin
                     face_ff <= '0; nseg_ff <= '0; state_ff <= B_FACE;
                  end else begin edge_ff <= edge_ff + 4'd1; state_ff <= B_EDGE; end
               end else begin axis_ff <= axis_ff + 2'd1; state_ff <= B_LERP; end
            end
            B_FACE: begin
               got = '0;
               s0 = '0;
               s1 = '0;
               for (int k = 0; k < 4; k++) begin
                  if (cut_ff[face_edge(face_ff, 2'(k))]) begin
                     if (got == 2'd0) s0 = cutp_ff[face_edge(face_ff, 2'(k))];
                     else if (got == 2'd1) s1 = cutp_ff[face_edge(face_ff, 2'(k))];
                     if (got != 2'd3) got = got + 2'd1;
                  end
               end
               seg_ff[nseg_ff][0] <= s0;
               seg_ff[nseg_ff][1] <= s1;
               if (got != 2'd0) nseg_ff <= nseg_ff + 3'd1;
               if (face_ff == 3'd5) begin
                  ci_ff <= '0; cj_ff <= 3'd1; state_ff <= B_CHAIN;
               end else face_ff <= face_ff + 3'd1;
            end
            B_CHAIN: begin
               // one (i, j) pair a cycle
               if (ci_ff >= nseg_ff || cj_ff >= nseg_ff) begin
                  if (ci_ff >= nseg_ff) begin
                     oi_ff <= '0;
                     state_ff <= (nseg_ff == '0) ? B_IDLE : B_EMIT;
                  end else begin ci_ff <= ci_ff + 3'd1; cj_ff <= ci_ff + 3'd2; end
               end else begin
                  want = seg_ff[ci_ff][1];
                  hit0 = (seg_ff[cj_ff][0] == want);
                  hit1 = (seg_ff[cj_ff][1] == want);
                  t0 = hit1 ? seg_ff[cj_ff][1] : seg_ff[cj_ff][0];
                  t1 = hit1 ? seg_ff[cj_ff][0] : seg_ff[cj_ff][1];
                  if (hit0 || hit1) begin
                     if (cj_ff != ci_ff + 3'd1) begin
                        seg_ff[ci_ff + 3'd1][0] <= t0;
                        seg_ff[ci_ff + 3'd1][1] <= t1;
                        seg_ff[cj_ff][0] <= seg_ff[ci_ff + 3'd1][0];
                        seg_ff[cj_ff][1] <= seg_ff[ci_ff + 3'd1][1];
                     end else begin
                        seg_ff[cj_ff][0] <= t0;
                        seg_ff[cj_ff][1] <= t1;
                     end
                  end
                  cj_ff <= cj_ff + 3'd1;
               end
            end
            B_EMIT: if (!rsp_stall) begin
               if (rsp_last) state_ff <= B_IDLE;
               else oi_ff <= oi_ff + 3'd1;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- hdl/plane_box_slice_polygon_core.sv -----
// Top level of the plane/box slice polygon core.
// Depends on pbsp_pkg, pbsp_front, pbsp_queue, pbsp_back.
`default_nettype none
// One plane a*x+b*y+c*z+d=0 goes in per item and 0 to 6 polygon vertices
// come out, the cut of the plane through the box held in the six csr
// registers (Q16.16). The front end forms the 24 corner products with one
// multiplier and hands distances and cut flags through a queue of
// QueueDepth entries (DefFifoDepth by default). The back end scans every
// box edge and runs a bit-serial divider (31 quotient bits) and then an
// interpolation on each cut edge, then goes through the six faces and the
// chaining of the segments and emits one vertex per cycle while rsp_stall
// is low. Each end takes a new plane only when it is idle.
// Write the box only while the core is idle.
module plane_box_slice_polygon_core #(
   parameter int QueueDepth = pbsp_pkg::DefFifoDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic signed [31:0] req_plane_a,
   input  wire logic signed [31:0] req_plane_b,
   input  wire logic signed [31:0] req_plane_c,
   input  wire logic signed [31:0] req_plane_d,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_y,
   output logic signed [31:0] rsp_vertex_z,
   output logic [2:0]       rsp_vertex_index,
   output logic             rsp_last_vertex,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import pbsp_pkg::*;

   logic signed [31:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff, min_z_ff, max_z_ff;
   box_type box;
   plane_type plane;
   logic fq_valid, fq_stall, qb_valid, qb_stall;
   logic signed [63:0] fq_dist [8];
   logic signed [63:0] qb_dist [8];
   logic [11:0] fq_cut, qb_cut;
   vtx_type vtx;

   // Hold the box registers; ignore indexes past the list.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= -32'sd65536; max_x_ff <= 32'sd65536;
         min_y_ff <= -32'sd65536; max_y_ff <= 32'sd65536;
         min_z_ff <= -32'sd65536; max_z_ff <= 32'sd65536;
      end else if (csr_write) begin
         case (csr_index)
            REG_MIN_X: min_x_ff <= csr_data;
            REG_MAX_X: max_x_ff <= csr_data;
            REG_MIN_Y: min_y_ff <= csr_data;
            REG_MAX_Y: max_y_ff <= csr_data;
            REG_MIN_Z: min_z_ff <= csr_data;
            REG_MAX_Z: max_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Corner i: x max on bit 2, y max on corners 2,3,6,7, z max on 1,2,5,6.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         box.corner[i].x = (i[2]) ? max_x_ff : min_x_ff;
         box.corner[i].y = (i[1]) ? max_y_ff : min_y_ff;
         box.corner[i].z = (i[1] ^ i[0]) ? max_z_ff : min_z_ff;
      end
   end

   assign plane = '{a: req_plane_a, b: req_plane_b, c: req_plane_c, d: req_plane_d};

   pbsp_front u_front (
      .clock, .reset, .req_valid, .req_stall, .plane, .box,
      .q_valid(fq_valid), .q_stall(fq_stall), .q_dist(fq_dist), .q_cut(fq_cut)
   );

   pbsp_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset, .in_valid(fq_valid), .in_stall(fq_stall), .in_dist(fq_dist),
      .in_cut(fq_cut), .out_valid(qb_valid), .out_stall(qb_stall),
      .out_dist(qb_dist), .out_cut(qb_cut)
   );

   pbsp_back u_back (
      .clock, .reset, .in_valid(qb_valid), .in_stall(qb_stall), .in_dist(qb_dist),
      .in_cut(qb_cut), .box, .rsp_valid, .rsp_stall, .rsp_vtx(vtx),
      .rsp_index(rsp_vertex_index), .rsp_last(rsp_last_vertex)
   );

   assign rsp_vertex_x = vtx.x;
   assign rsp_vertex_y = vtx.y;
   assign rsp_vertex_z = vtx.z;
endmodule
`default_nettype wire
